### sv/mwpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpm_pkg
// shared types and constants of the multi-word prefix matcher
// ----------------------------------------------------------------------------
package mwpm_pkg;

  localparam int MAX_ENTRIES_DEF  = 16;
  localparam int MAX_WORD_LEN_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE      = 1'd1;

  localparam logic [4:0] ENTRIES_IN_USE_RST = 5'd12;

  typedef struct packed {
    logic       mode;
    logic [3:0] entry;
    logic [3:0] position;
    logic [7:0] char_value;
    logic       first;
    logic       last;
  } item_word_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  match_index;
    logic [15:0] consumed;
  } result_word_t;

endpackage

### sv/mwpm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpm_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
interface mwpm_stream_if #(
  parameter type word_t = mwpm_pkg::item_word_t
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/multi_word_prefix_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_word_prefix_matcher
// dictionary of words loaded byte by byte; subject bytes are matched against
// every live word by one comparator walking the dictionary memory
//
// a load word is written to the dictionary memory when it is accepted; a match
//   word that ends the match without a scan goes to S_FIN, a scanned one first
//   passes S_SCAN, S_DRAIN and S_EVAL (single read port and comparator visit
//   each word in turn); items are taken only in S_IDLE, one load word per cycle
// reset: synchronous, clears tracks, counters and control state, sets entries in
//   use to 12; dictionary memory is not cleared and holds undefined bytes until written
// ----------------------------------------------------------------------------
module multi_word_prefix_matcher #(
  parameter int MAX_ENTRIES  = mwpm_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_WORD_LEN = mwpm_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  mwpm_stream_if.sink                    items,
  mwpm_stream_if.source                  results,
  input  logic                           cfg_we,
  input  logic [mwpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mwpm_pkg::*;

  localparam int DEPTH  = MAX_ENTRIES * MAX_WORD_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int COL_W  = $clog2(MAX_WORD_LEN + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_SKIP  = 2'd1;
  localparam logic [1:0] P_MATCH = 2'd2;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  logic [2:0]             state;
  logic [1:0]             phase;
  logic [MAX_ENTRIES-1:0] live;
  logic [IDX_W-1:0]       best_index;
  logic                   best_valid;
  logic [COL_W-1:0]       column;
  logic [15:0]            consumed;
  logic [7:0]             ch_q;
  logic                   last_q;
  logic [IDX_W-1:0]       idx;
  logic [ADDR_W-1:0]      addr;
  logic [7:0]             rd_data;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_vld;
  logic [4:0]             entries_in_use;
  logic                   fold_case;
  logic                   out_valid;
  result_word_t           out_word;

  logic [7:0] mem [DEPTH];

  item_word_t             iw;
  logic                   acc;
  logic                   load_ok;
  logic [ADDR_W-1:0]      waddr;
  logic [MAX_ENTRIES-1:0] smask;
  logic [MAX_ENTRIES-1:0] live_e;
  logic [1:0]             phase_e;
  logic [15:0]            cons_e;
  logic [COL_W-1:0]       col_e;
  logic                   col_over;
  logic [7:0]             d;
  logic                   hit;
  logic [7:0]             best_ext;
  logic                   out_free;

  assign iw          = items.payload;
  assign items.ready = (state == S_IDLE);
  assign acc         = items.valid && items.ready;

  assign results.valid   = out_valid;
  assign results.payload = out_word;
  assign out_free        = !out_valid || results.ready;

  assign load_ok = (32'(iw.entry) < 32'(MAX_ENTRIES)) &&
                   (32'(iw.position) < 32'(MAX_WORD_LEN));
  assign waddr   = ADDR_W'(32'(iw.entry) * 32'(MAX_WORD_LEN) + 32'(iw.position));

  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      smask[k] = (32'(k) < 32'(entries_in_use));
    end
  end

  assign live_e  = iw.first ? smask : live;
  assign phase_e = iw.first ? P_SKIP : phase;
  assign cons_e  = iw.first ? 16'd0 : consumed;
  assign col_e   = iw.first ? '0 : column;

  assign col_over = (column == COL_W'(MAX_WORD_LEN));
  assign d        = col_over ? 8'd0 : rd_data;
  assign hit      = (ch_q == d) || (fold_case && (lower_of(ch_q) == d));
  assign best_ext = 8'(best_index);

  always_ff @(posedge clk) begin
    if (acc && !iw.mode && load_ok) begin
      mem[waddr] <= iw.char_value;
    end
    if (state == S_SCAN) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_IN_USE_RST;
      fold_case      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
        CFG_FOLD_CASE:      fold_case      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= P_IDLE;
      live       <= '0;
      best_index <= '0;
      best_valid <= 1'b0;
      column     <= '0;
      consumed   <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
      if (out_valid && results.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      if (rd_vld && live[rd_idx]) begin
        if (d != 8'd0) begin
          if (hit) begin
            best_index <= rd_idx;
            best_valid <= 1'b1;
          end else begin
            live[rd_idx] <= 1'b0;
          end
        end else begin
          live[rd_idx] <= 1'b0;
          best_index   <= rd_idx;
          best_valid   <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (acc && iw.mode) begin
            live     <= live_e;
            column   <= col_e;
            if (iw.first) begin
              best_index <= '0;
              best_valid <= 1'b0;
            end
            if (phase_e == P_IDLE) begin
              phase <= P_IDLE;
            end else if (iw.char_value == 8'd0) begin
              consumed <= cons_e;
              phase    <= P_IDLE;
              state    <= S_FIN;
            end else if (phase_e == P_SKIP && !is_alnum(iw.char_value)) begin
              consumed <= sat_inc(cons_e);
              if (iw.last) begin
                phase <= P_IDLE;
                state <= S_FIN;
              end else begin
                phase <= P_SKIP;
              end
            end else if (live_e == '0) begin
              consumed <= cons_e;
              phase    <= P_IDLE;
              state    <= S_FIN;
            end else begin
              consumed <= cons_e;
              phase    <= P_MATCH;
              state    <= S_SCAN;
              idx      <= '0;
              addr     <= ADDR_W'(col_e);
              ch_q     <= iw.char_value;
              last_q   <= iw.last;
            end
          end
        end
        S_SCAN: begin
          rd_idx <= idx;
          addr   <= addr + ADDR_W'(MAX_WORD_LEN);
          idx    <= idx + IDX_W'(1);
          if (idx == IDX_W'(MAX_ENTRIES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (live == '0) begin
            phase <= P_IDLE;
            state <= S_FIN;
          end else begin
            consumed <= sat_inc(consumed);
            if (!col_over) begin
              column <= column + COL_W'(1);
            end
            if (last_q) begin
              phase <= P_IDLE;
              state <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_word.found       <= best_valid;
            out_word.match_index <= best_valid ? best_ext[3:0] : 4'd0;
            out_word.consumed    <= consumed;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // tracks only die while the dictionary is walked
  a_live_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN) |=> ((live & ~$past(live)) == '0))
    else $error("live track revived during scan");

  a_eval_in_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (phase == P_MATCH))
    else $error("scan evaluated outside match phase");

  a_column_sat: assert property (@(posedge clk) disable iff (rst)
    column <= COL_W'(MAX_WORD_LEN))
    else $error("column past word length");

  a_no_index_without_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.found) |-> (out_word.match_index == 4'd0))
    else $error("index reported without a match");

endmodule
